// ----- rtl/hcks_pkg.sv -----
package hcks_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_FINISH,
    ST_OUT
  } state_t;

  localparam int NumKeyWords  = 4;
  localparam int BlockBytes   = 32;
  localparam int MsgBytes     = 40;
  localparam int NumRounds    = 12;
  localparam int StepsPerRnd  = 8;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] ParamWord = 64'h0000000001010020;

  // message schedule, 10 rows of 16 word indexes
  localparam logic [3:0] SIGMA [10][16] = '{
    '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
    '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
    '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
    '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
    '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
    '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
    '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
    '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
    '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
  };

  // v indexes a,b,c,d for each of the eight mixing steps of a round
  localparam logic [3:0] MIX_IDX [8][4] = '{
    '{0, 4,  8, 12}, '{1, 5,  9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
    '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7,  8, 13}, '{3, 4,  9, 14}
  };

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
    rotr64 = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- rtl/hash_counter_keystream_xor_unit.sv -----
// Byte-wide counter-mode stream cipher on BLAKE2b-256: each output beat is the
// input byte XOR one keystream byte. A fresh 32-byte keystream block is made
// every 32 bytes, after a byte marked last, and after a key write, in the shared
// mixing unit (12 rounds x 8 steps x 2 halves plus start and finish) when the
// first byte of a block arrives; a new byte is taken only once the last result
// has left. Keys must be written only when idle; the unit does not enforce it.
module hash_counter_keystream_xor_unit
  import hcks_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  state_t       state_r, state_nxt;
  logic [255:0] key_r;
  logic [63:0]  counter_r, counter_nxt;
  logic [4:0]   offset_r, offset_nxt;
  logic         ks_valid_r, ks_valid_nxt;
  logic [255:0] ks_r;
  in_item_t     item_r;
  out_item_t    res_r;
  logic         start;
  logic         done;
  logic [255:0] digest;
  logic [7:0]   ks_byte;

  hcks_core u_core (
    .clk(clk), .rst_n(rst_n), .start(start), .key(key_r),
    .counter(counter_r), .done(done), .digest(digest)
  );

  assign ks_byte = ks_r[{offset_r, 3'b000} +: 8];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ks_valid_r ? ST_FINISH : ST_HASH;
      ST_HASH:   if (done) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    start     = (state_r == ST_IDLE) && in_valid && !ks_valid_r;
  end

  // counter, offset and keystream validity
  always_comb begin
    counter_nxt  = counter_r;
    offset_nxt   = offset_r;
    ks_valid_nxt = ks_valid_r;
    if (state_r == ST_HASH && done) ks_valid_nxt = 1'b1;
    if (state_r == ST_FINISH) begin
      offset_nxt = offset_r + 5'd1;
      if (offset_r == 5'(BlockBytes - 1)) begin
        counter_nxt  = counter_r + 64'd1;
        ks_valid_nxt = 1'b0;
      end
      if (item_r.last_byte) begin
        counter_nxt  = '0;
        offset_nxt   = '0;
        ks_valid_nxt = 1'b0;
      end
    end
    if (cfg_we) ks_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      key_r      <= '0;
      counter_r  <= '0;
      offset_r   <= '0;
      ks_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      counter_r  <= counter_nxt;
      offset_r   <= offset_nxt;
      ks_valid_r <= ks_valid_nxt;
      if (cfg_we) key_r[64*cfg_index +: 64] <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    if (state_r == ST_HASH && done) ks_r <= digest;
    if (state_r == ST_FINISH) begin
      res_r.out_byte <= item_r.data_byte ^ ks_byte;
      res_r.out_last <= item_r.last_byte;
    end
  end

  assign out_data = res_r;

endmodule

// ----- rtl/hcks_mix.sv -----
// one half of the mixing step: three adds, two xors and two rotations
module hcks_mix
  import hcks_pkg::*;
(
  input  logic        second_half,
  input  logic [63:0] a_in,
  input  logic [63:0] b_in,
  input  logic [63:0] c_in,
  input  logic [63:0] d_in,
  input  logic [63:0] m_in,
  output logic [63:0] a_out,
  output logic [63:0] b_out,
  output logic [63:0] c_out,
  output logic [63:0] d_out
);

  logic [63:0] dx;
  logic [63:0] bx;

  always_comb begin
    a_out = a_in + b_in + m_in;
    dx    = d_in ^ a_out;
    d_out = second_half ? rotr64(dx, 16) : rotr64(dx, 32);
    c_out = c_in + d_out;
    bx    = b_in ^ c_out;
    b_out = second_half ? rotr64(bx, 63) : rotr64(bx, 24);
  end

endmodule

// ----- rtl/hcks_core.sv -----
// compression engine: 12 rounds x 8 steps x 2 halves through one shared mix unit
module hcks_core
  import hcks_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] key,
  input  logic [63:0]  counter,
  output logic         done,
  output logic [255:0] digest
);

  logic [63:0] v_r [16];
  logic [63:0] v_nxt [16];
  logic [3:0]  round_r, round_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        half_r, half_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] m [16];
  logic [3:0]  ai, bi, ci, di, mi;
  logic [3:0]  srow;
  logic [63:0] a_o, b_o, c_o, d_o;

  // message words: key, counter, then zeros
  always_comb begin
    for (int i = 0; i < 16; i++) m[i] = '0;
    for (int i = 0; i < NumKeyWords; i++) m[i] = key[64*i +: 64];
    m[4] = counter;
  end

  always_comb begin
    srow = (round_r >= 4'd10) ? round_r - 4'd10 : round_r;
    ai = MIX_IDX[step_r][0];
    bi = MIX_IDX[step_r][1];
    ci = MIX_IDX[step_r][2];
    di = MIX_IDX[step_r][3];
    mi = SIGMA[srow][{step_r, half_r}];
  end

  hcks_mix u_mix (
    .second_half(half_r),
    .a_in(v_r[ai]), .b_in(v_r[bi]), .c_in(v_r[ci]), .d_in(v_r[di]),
    .m_in(m[mi]),
    .a_out(a_o), .b_out(b_o), .c_out(c_o), .d_out(d_o)
  );

  // sequencer and working vector
  always_comb begin
    v_nxt     = v_r;
    round_nxt = round_r;
    step_nxt  = step_r;
    half_nxt  = half_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        v_nxt[i]     = IV[i];
        v_nxt[i + 8] = IV[i];
      end
      v_nxt[0]  = IV[0] ^ ParamWord;
      v_nxt[12] = IV[4] ^ 64'(MsgBytes);
      v_nxt[14] = ~IV[6];
      round_nxt = '0;
      step_nxt  = '0;
      half_nxt  = 1'b0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      v_nxt[ai] = a_o;
      v_nxt[bi] = b_o;
      v_nxt[ci] = c_o;
      v_nxt[di] = d_o;
      half_nxt  = ~half_r;
      if (half_r) begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(StepsPerRnd - 1)) begin
          if (round_r == 4'(NumRounds - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            round_nxt = round_r + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    round_r <= round_nxt;
    step_r  <= step_nxt;
    half_r  <= half_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // feed-forward into the chaining value, first four words only
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [63:0] h0;
      h0 = (i == 0) ? (IV[0] ^ ParamWord) : IV[i];
      digest[64*i +: 64] = h0 ^ v_r[i] ^ v_r[i + 8];
    end
  end

  assign done = done_r;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import hcks_pkg::*;

  // keystream predictor and the store of bytes still owed by the block
  class cipher_scoreboard;
    bit [63:0]  key_w [4];
    bit [63:0]  blk_ctr;
    bit [4:0]   offs;
    bit [7:0]   ks_buf [32];
    bit         ks_ok;
    bit [63:0]  v [16];
    bit [63:0]  m [16];
    out_item_t  owed [$];
    int         errors;
    int         checked;

    bit [63:0] init_vec [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };
    int sched [10][16] = '{
      '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
      '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
      '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
      '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
      '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
      '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
      '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
      '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
      '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
      '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
    };

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      blk_ctr = '0;
      offs    = '0;
      ks_ok   = 1'b0;
      errors  = 0;
      checked = 0;
    endfunction

    function bit [63:0] ror(bit [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void quarter(int a, int b, int c, int d, bit [63:0] x, bit [63:0] y);
      v[a] = v[a] + v[b] + x; v[d] = ror(v[d] ^ v[a], 32);
      v[c] = v[c] + v[d];     v[b] = ror(v[b] ^ v[c], 24);
      v[a] = v[a] + v[b] + y; v[d] = ror(v[d] ^ v[a], 16);
      v[c] = v[c] + v[d];     v[b] = ror(v[b] ^ v[c], 63);
    endfunction

    // one compression over key words plus counter, 40 message bytes
    function void hash_block();
      bit [63:0] h [8];
      int r;
      foreach (m[i]) m[i] = '0;
      for (int i = 0; i < 4; i++) m[i] = key_w[i];
      m[4] = blk_ctr;
      for (int i = 0; i < 8; i++) h[i] = init_vec[i];
      h[0] ^= 64'h0000000001010020;
      for (int i = 0; i < 8; i++) begin
        v[i] = h[i];
        v[i+8] = init_vec[i];
      end
      v[12] ^= 64'd40;
      v[14] = ~v[14];
      for (r = 0; r < 12; r++) begin
        quarter(0, 4,  8, 12, m[sched[r%10][0]],  m[sched[r%10][1]]);
        quarter(1, 5,  9, 13, m[sched[r%10][2]],  m[sched[r%10][3]]);
        quarter(2, 6, 10, 14, m[sched[r%10][4]],  m[sched[r%10][5]]);
        quarter(3, 7, 11, 15, m[sched[r%10][6]],  m[sched[r%10][7]]);
        quarter(0, 5, 10, 15, m[sched[r%10][8]],  m[sched[r%10][9]]);
        quarter(1, 6, 11, 12, m[sched[r%10][10]], m[sched[r%10][11]]);
        quarter(2, 7,  8, 13, m[sched[r%10][12]], m[sched[r%10][13]]);
        quarter(3, 4,  9, 14, m[sched[r%10][14]], m[sched[r%10][15]]);
      end
      for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i+8];
      for (int i = 0; i < 32; i++) ks_buf[i] = h[i/8] >> (8 * (i % 8));
    endfunction

    // any key write forces a fresh block at the same counter and offset
    function void set_key(int idx, bit [63:0] val);
      key_w[idx] = val;
      ks_ok = 1'b0;
    endfunction

    function void note_input(in_item_t beat);
      out_item_t e;
      if (!ks_ok) begin
        hash_block();
        ks_ok = 1'b1;
      end
      e.out_byte = beat.data_byte ^ ks_buf[offs];
      e.out_last = beat.last_byte;
      owed.push_back(e);
      offs = offs + 5'd1;
      if (offs == 0) begin
        blk_ctr = blk_ctr + 64'd1;
        ks_ok = 1'b0;
      end
      if (beat.last_byte) begin
        blk_ctr = '0;
        offs    = '0;
        ks_ok   = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected beat byte=%02h last=%0b", got.out_byte, got.out_last));
      end else begin
        e = owed.pop_front();
        if (got.out_byte !== e.out_byte)
          report($sformatf("out_byte got %02h want %02h", got.out_byte, e.out_byte));
        if (got.out_last !== e.out_last)
          report($sformatf("out_last got %0b want %0b", got.out_last, e.out_last));
      end
    endtask

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  cipher_scoreboard sb;
  bit  long_hold_req;
  int  sent;
  int  msgs;
  int  key_writes;

  hash_counter_keystream_xor_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: random stalls, one long hold on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        long_hold_req = 1'b0;
      end else if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    #20ms;
    $display("hash_counter_keystream_xor_unit regression: fail");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one beat after an optional gap, return once accepted
  task send_beat(bit [7:0] data, bit last, int gap);
    in_item_t b;
    b.data_byte = data;
    b.last_byte = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b);
    sent++;
    if (last) msgs++;
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_key(int idx, bit [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[1:0];
    cfg_wdata <= val;
    sb.set_key(idx, val);
    key_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task random_messages(int count);
    int len;
    int r;
    int target;
    bit noisy;
    target = sent + count;
    while (sent < target) begin
      r = $urandom_range(0, 19);
      if (r < 15) len = $urandom_range(1, 40);
      else if (r < 19) len = $urandom_range(41, 100);
      else len = 1;
      noisy = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++)
        send_beat($urandom_range(0, 255),
                  (i == len - 1) || (noisy && $urandom_range(0, 7) == 0), pick_gap());
    end
  endtask

  initial begin
    bit [63:0] kv;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    long_hold_req = 1'b0;
    sent = 0;
    msgs = 0;
    key_writes = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero key, extreme bytes, one-byte messages, short message
    for (int i = 0; i < 4; i++) write_key(i, 64'h0);
    send_beat(8'h00, 1'b1, 0);
    send_beat(8'hff, 1'b1, 0);
    send_beat(8'hff, 1'b0, 2);
    for (int i = 0; i < 19; i++) send_beat((i % 2) ? 8'hff : 8'h00, i == 18, 0);
    drain();

    // key write in the middle of a message keeps counter and offset
    send_beat(8'h5a, 1'b0, 0);
    send_beat(8'ha5, 1'b0, 0);
    drain();
    write_key(2, 64'hffff_ffff_ffff_ffff);
    send_beat(8'h3c, 1'b1, 0);
    drain();

    // phases over several keys, all-ones among them
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 4; i++) begin
        case (ph)
          0: kv = 64'hffff_ffff_ffff_ffff;
          1: kv = 64'h0;
          default: kv = {$urandom, $urandom};
        endcase
        write_key(i, kv);
      end
      if (ph == 2) long_hold_req = 1'b1;
      random_messages(330);
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d bytes in %0d messages, %0d key writes, %0d beats checked",
             sent, msgs, key_writes, sb.checked);
    $display("includes block crossings, mid-message rekeying and a long output stall");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hash_counter_keystream_xor_unit regression: pass");
    end else begin
      $display("hash_counter_keystream_xor_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hcks_pkg.sv
rtl/hcks_mix.sv
rtl/hcks_core.sv
rtl/hash_counter_keystream_xor_unit.sv
sim/testbench.sv
